// ===== rtl/dla_pkg.sv =====
package dla_pkg;

  // Stream payload layout
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned SPAWN_COL_LSB = 0;
  localparam int unsigned RAND_H_LSB    = 8;
  localparam int unsigned RAND_V_LSB    = 24;
  localparam int unsigned READ_COL_LSB  = 40;
  localparam int unsigned READ_ROW_LSB  = 48;

  localparam int unsigned LABEL_LSB     = 0;
  localparam int unsigned WCOL_LSB      = 5;
  localparam int unsigned WROW_LSB      = 13;
  localparam int unsigned STUCK_BIT     = 19;
  localparam int unsigned DONE_BIT      = 20;

  localparam int unsigned LABEL_W  = 5;
  localparam int unsigned COLF_W   = 8;
  localparam int unsigned ROWF_W   = 6;
  localparam int unsigned RAND_W   = 16;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 2'd3;

  localparam logic [8:0]  COLS_RESET  = 9'd182;
  localparam logic [6:0]  ROWS_RESET  = 7'd60;
  localparam logic [16:0] LEFT_RESET  = 17'd32768;
  localparam logic [16:0] DOWN_RESET  = 17'd33423;

  // Row zero is seeded with labels 1 to SEED_LABELS, repeating by column
  localparam logic [LABEL_W-1:0] SEED_LABELS = 5'd26;

  // Neighborhood offset along one axis
  typedef enum logic [1:0] {
    OFS_NEG,
    OFS_MID,
    OFS_POS
  } ofs_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // accept the input transaction, spawn or clamp the walker
    logic clr_step;  // write one entry of the clearing sweep
    logic scan_rd;   // read one neighbor cell
    ofs_e dc;        // column offset of the neighbor
    ofs_e dr;        // row offset of the neighbor
    logic rd_issue;  // read the cell addressed by a read transaction
    logic commit;    // update walker state and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic finished;  // cluster has reached the top rows
    logic clr_last;  // clearing sweep is at its last entry
  } sts_t;

endpackage

// ===== rtl/dla_ram.sv =====
module dla_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/dla_ctrl.sv =====
module dla_ctrl import dla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  logic s_func_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  ofs_e   dc_q, dr_q;
  logic   out_valid_q;
  logic   accept, out_free, scan_last;

  function automatic ofs_e ofs_next(ofs_e o);
    unique case (o)
      OFS_NEG: return OFS_MID;
      OFS_MID: return OFS_POS;
      default: return OFS_NEG;
    endcase
  endfunction

  // Handshake and command decode
  always_comb begin
    s_tready_o = (state_q == ST_IDLE);
    accept     = s_tvalid_i && s_tready_o;
    out_free   = !out_valid_q || m_tready_i;
    scan_last  = (dc_q == OFS_POS) && (dr_q == OFS_POS);

    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.clr_step = (state_q == ST_CLEAR);
    cmd_o.scan_rd  = (state_q == ST_SCAN);
    cmd_o.dc       = dc_q;
    cmd_o.dr       = dr_q;
    cmd_o.rd_issue = (state_q == ST_RD);
    cmd_o.commit   = (state_q == ST_FINISH) && out_free;
  end

  assign m_tvalid_o = out_valid_q;

  // Sequencer: clearing sweep, nine neighbor reads or one addressed read, drain, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      dc_q        <= OFS_NEG;
      dr_q        <= OFS_NEG;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            dc_q <= OFS_NEG;
            dr_q <= OFS_NEG;
            if (s_func_i) begin
              state_q <= ST_RD;
            end else if (sts_i.finished) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else if (dr_q == OFS_POS) begin
            dr_q <= OFS_NEG;
            dc_q <= ofs_next(dc_q);
          end else begin
            dr_q <= ofs_next(dr_q);
          end
        end
        ST_RD: begin
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Result register occupancy
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/dla_dp.sv =====
module dla_dp import dla_pkg::*; #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   item_user_i,
  input  logic [IN_TDATA_W-1:0]  item_data_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic [OUT_TDATA_W-1:0] res_data_o
);

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CNW   = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam int unsigned RNW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers
  logic [8:0]  cols_q;
  logic [6:0]  rows_q;
  logic [16:0] left_q, down_q;

  // Walker and run state
  logic [CW-1:0] walk_col_q, walk_col_d;
  logic [RW-1:0] walk_row_q, walk_row_d;
  logic          active_q, active_d;
  logic          finished_q, finished_d;
  logic          stuck_d;

  // Captured transaction fields
  logic              func_q, ign_q;
  logic [RAND_W-1:0] rand_h_q, rand_v_q;
  logic [COLF_W-1:0] read_col_q;
  logic [ROWF_W-1:0] read_row_q;

  // Scan and result
  logic [LABEL_W-1:0]     label_q;
  logic                   acc_pend_q;
  logic [OUT_TDATA_W-1:0] res_q;

  // Clearing sweep
  logic [AW-1:0]      clr_addr_q;
  logic [RW-1:0]      clr_row_q;
  logic [LABEL_W-1:0] clr_seed_q;

  // Effective grid bounds
  logic [CNW-1:0] cols_raw, cols_eff;
  logic [RNW-1:0] rows_raw, rows_eff;
  logic [CW-1:0]  col_max;
  logic [RW-1:0]  row_max;

  logic [COLF_W-1:0] spawn_col;
  logic [CW-1:0]     base_col, col_left, col_right, scan_col;
  logic [RW-1:0]     base_row, scan_row;
  logic              at_top, at_bot, scan_skip, rd_inrange, stick;
  logic [AW-1:0]     scan_addr, rd_addr, walk_addr;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LABEL_W-1:0] ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] grid_addr(logic [CW-1:0] c, logic [RW-1:0] r);
    return AW'(c) * AW'(MAX_ROWS) + AW'(r);
  endfunction

  // Bounds clamped into the range the grid supports
  always_comb begin
    cols_raw = CNW'(cols_q);
    rows_raw = RNW'(rows_q);
    if (cols_raw < CNW'(2)) begin
      cols_eff = CNW'(2);
    end else if (cols_raw > CNW'(MAX_COLS)) begin
      cols_eff = CNW'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
    if (rows_raw < RNW'(3)) begin
      rows_eff = RNW'(3);
    end else if (rows_raw > RNW'(MAX_ROWS)) begin
      rows_eff = RNW'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
    col_max = CW'(cols_eff - CNW'(1));
    row_max = RW'(rows_eff - RNW'(1));
  end

  // Neighbor coordinates with column wrap and row clipping
  always_comb begin
    col_left  = (walk_col_q == '0) ? col_max : walk_col_q - CW'(1);
    col_right = (walk_col_q == col_max) ? '0 : walk_col_q + CW'(1);
    at_top    = (walk_row_q == row_max);
    at_bot    = (walk_row_q == '0);

    case (cmd_i.dc)
      OFS_NEG: scan_col = col_left;
      OFS_POS: scan_col = col_right;
      default: scan_col = walk_col_q;
    endcase
    case (cmd_i.dr)
      OFS_NEG: scan_row = walk_row_q - RW'(1);
      OFS_POS: scan_row = walk_row_q + RW'(1);
      default: scan_row = walk_row_q;
    endcase
    scan_skip = ((cmd_i.dr == OFS_NEG) && at_bot) || ((cmd_i.dr == OFS_POS) && at_top);
    scan_addr = grid_addr(scan_col, scan_row);

    rd_inrange = (CNW'(read_col_q) <= CNW'(col_max)) && (RNW'(read_row_q) <= RNW'(row_max));
    rd_addr    = grid_addr(CW'(read_col_q), RW'(read_row_q));
    walk_addr  = grid_addr(walk_col_q, walk_row_q);
  end

  // Walker update on capture (spawn and clamp) and on commit (stick or move)
  always_comb begin
    walk_col_d = walk_col_q;
    walk_row_d = walk_row_q;
    active_d   = active_q;
    finished_d = finished_q;
    stuck_d    = 1'b0;
    stick      = (label_q != '0);
    spawn_col  = item_data_i[SPAWN_COL_LSB +: COLF_W];
    base_col   = walk_col_q;
    base_row   = walk_row_q;

    if (cmd_i.capture && !item_user_i && !finished_q) begin
      if (!active_q) begin
        base_col = (CNW'(spawn_col) <= CNW'(col_max)) ? CW'(spawn_col) : col_max;
        base_row = row_max;
      end
      walk_col_d = (base_col > col_max) ? col_max : base_col;
      walk_row_d = (base_row > row_max) ? row_max : base_row;
      active_d   = 1'b1;
    end

    if (cmd_i.commit && !func_q && !ign_q) begin
      if (stick) begin
        stuck_d  = 1'b1;
        active_d = 1'b0;
        if (RNW'(walk_row_q) + RNW'(2) >= rows_eff) begin
          finished_d = 1'b1;
        end
      end else begin
        walk_col_d = ({1'b0, rand_h_q} < left_q) ? col_left : col_right;
        if ({1'b0, rand_v_q} < down_q) begin
          walk_row_d = at_bot ? walk_row_q : walk_row_q - RW'(1);
        end else begin
          walk_row_d = at_top ? walk_row_q : walk_row_q + RW'(1);
        end
      end
    end
  end

  // Grid memory port selection
  always_comb begin
    ram_re    = cmd_i.scan_rd || cmd_i.rd_issue;
    ram_raddr = cmd_i.rd_issue ? rd_addr : scan_addr;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = (clr_row_q == '0) ? clr_seed_q : '0;
    end else begin
      ram_we    = cmd_i.commit && !func_q && !ign_q && stick;
      ram_waddr = walk_addr;
      ram_wdata = label_q;
    end
  end

  dla_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state: configuration, walker, sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COLS_RESET;
      rows_q     <= ROWS_RESET;
      left_q     <= LEFT_RESET;
      down_q     <= DOWN_RESET;
      walk_col_q <= '0;
      walk_row_q <= '0;
      active_q   <= 1'b0;
      finished_q <= 1'b0;
      acc_pend_q <= 1'b0;
      clr_addr_q <= '0;
      clr_row_q  <= '0;
      clr_seed_q <= LABEL_W'(1);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COLS_IN_USE:    cols_q <= cfg_data_i[8:0];
          REG_ROWS_IN_USE:    rows_q <= cfg_data_i[6:0];
          REG_LEFT_THRESHOLD: left_q <= cfg_data_i;
          REG_DOWN_THRESHOLD: down_q <= cfg_data_i;
          default: ;
        endcase
      end
      walk_col_q <= walk_col_d;
      walk_row_q <= walk_row_d;
      active_q   <= active_d;
      finished_q <= finished_d;
      acc_pend_q <= (cmd_i.scan_rd && !scan_skip) || (cmd_i.rd_issue && rd_inrange);

      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_row_q == RW'(MAX_ROWS - 1)) begin
          clr_row_q  <= '0;
          clr_seed_q <= (clr_seed_q == SEED_LABELS) ? LABEL_W'(1) : clr_seed_q + LABEL_W'(1);
        end else begin
          clr_row_q <= clr_row_q + RW'(1);
        end
      end
    end
  end

  // Payload: captured fields, label accumulator, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= item_user_i;
      ign_q      <= !item_user_i && finished_q;
      rand_h_q   <= item_data_i[RAND_H_LSB +: RAND_W];
      rand_v_q   <= item_data_i[RAND_V_LSB +: RAND_W];
      read_col_q <= item_data_i[READ_COL_LSB +: COLF_W];
      read_row_q <= item_data_i[READ_ROW_LSB +: ROWF_W];
      label_q    <= '0;
    end else if (acc_pend_q && (ram_rdata != '0)) begin
      // The last occupied neighbor in scan order wins
      label_q <= ram_rdata;
    end
    if (cmd_i.commit) begin
      res_q <= {3'b000, finished_d, stuck_d, ROWF_W'(walk_row_d), COLF_W'(walk_col_d), label_q};
    end
  end

  assign sts_o.finished = finished_q;
  assign sts_o.clr_last = (clr_addr_q == AW'(DEPTH - 1));
  assign res_data_o     = res_q;

endmodule

// ===== rtl/diffusion_aggregation_walker.sv =====
// Walk step: nine neighbor reads through the single read port of the grid RAM, then a
// drain state and a commit state. Read item: one addressed read, then drain and commit.
// Step after the run is finished: commit only. Commit waits for a free result register.
// A new input is taken the cycle after a result is loaded.
// After reset the grid RAM is swept once over its MAX_COLS * MAX_ROWS entries (16384 by default),
// seeding row zero and clearing the rest; no input is taken during the sweep.
module diffusion_aggregation_walker import dla_pkg::*; #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // spawn_col[7:0], rand_h[23:8], rand_v[39:24], read_col[47:40], read_row[53:48]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // label[4:0], walker_col[12:5], walker_row[18:13], stuck[19], done_res[20]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  dla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_func_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dla_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_user_i (s_axis_tuser),
    .item_data_i (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/dla_checker.sv =====
module dla_checker import dla_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A result waiting for the sink keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Items are processed one at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on two consecutive cycles");

  // Sticking always takes a nonzero label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[STUCK_BIT] |-> m_axis_tdata[LABEL_LSB +: LABEL_W] != '0)
    else $error("walker stuck with empty label");

  // Labels stay within the seeded alphabet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[LABEL_LSB +: LABEL_W] <= SEED_LABELS)
    else $error("label out of range");

endmodule

bind diffusion_aggregation_walker dla_checker u_dla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
